>>> hdl/sto_pkg.sv
// ----------------------------------------------------------------------------
// sto_pkg - shared types and constants of the sorted timeout queue
// Sizes, operation codes, status codes, sequencer states and the entry
// layout that the queue memory holds.
// ----------------------------------------------------------------------------
package sto_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int HANDLE_BITS = 8;
    localparam int MAX_RESULTS = 16;

    localparam int IDX_W    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 30;
    localparam int HANDLE_W = 8;
    localparam int MODE_W   = 3;
    localparam int STATUS_W = 2;

    localparam logic [TIME_W-1:0] SLEEP_INFINITE = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD     = 3'd0,
        MODE_CANCEL  = 3'd1,
        MODE_CHECK   = 3'd2,
        MODE_RESTART = 3'd3,
        MODE_SLEEP   = 3'd4
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_MISS = 2'd2
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADD_T,
        S_FIND_RD,
        S_FIND_EV,
        S_SHUP_RD,
        S_SHUP_WR,
        S_INS,
        S_CAN_RD,
        S_CAN_EV,
        S_SHDN_RD,
        S_SHDN_WR,
        S_CHK_RD,
        S_CHK_EV,
        S_POP_RD,
        S_POP_EV,
        S_RST_RD,
        S_RST_BASE,
        S_RST_RD2,
        S_RST_WR,
        S_SLP_RD,
        S_SLP_EV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [TIME_W-1:0]      due;
        logic [HANDLE_BITS-1:0] hdl;
    } t_entry;

    typedef struct packed {
        logic                 we;
        logic [IDX_W-1:0]     waddr;
        t_entry               wdata;
        logic [IDX_W-1:0]     raddr;
    } t_mem_req;

endpackage

>>> hdl/sorted_timeout_queue.sv
// ----------------------------------------------------------------------------
// sorted_timeout_queue - sorted queue of pending timeouts, wraparound time
// One word at a time: o_stall holds new input while an operation runs; the
//   sequencer and the single-read-port entry memory set the pace.
// Reset (synchronous, active low) empties the queue and drops any pending
//   result word; entry contents are not cleared, only the count.
// ----------------------------------------------------------------------------
//
// Entries are held in a small memory sorted by due time. Each operation is
// a walk over that memory under one sequencer: an address goes out in one
// cycle and the registered data is evaluated in the next. One shared
// adder/subtractor does every time calculation: now + delay, the wraparound
// compare (sign of a - b), the sleep remainder and the restart rebase.
// Results leave through an output register, so the next input word can be
// taken while a result still waits downstream.
module sorted_timeout_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [sto_pkg::MODE_W-1:0]     i_mode,
    input  logic [sto_pkg::HANDLE_W-1:0]   i_handle,
    input  logic [sto_pkg::DELAY_W-1:0]    i_delay_ms,
    input  logic [sto_pkg::TIME_W-1:0]     i_now,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [sto_pkg::HANDLE_W-1:0]   o_fired_handle,
    output logic                           o_fired,
    output logic [sto_pkg::TIME_W-1:0]     o_sleep_ms,
    output logic                           o_queue_empty,
    output logic [sto_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_last
);

    localparam int CW = sto_pkg::CNT_W;
    localparam int IW = sto_pkg::IDX_W;
    localparam int TW = sto_pkg::TIME_W;

    // Sequencer state and operand registers.
    sto_pkg::t_state                r_state, n_state;
    sto_pkg::t_mode                 r_mode, n_mode;
    logic [sto_pkg::HANDLE_BITS-1:0] r_h, n_h;
    logic [sto_pkg::DELAY_W-1:0]    r_delay, n_delay;
    logic [TW-1:0]                  r_now, n_now;
    logic [TW-1:0]                  r_t, n_t;         // new due time or rebase delta
    logic [CW-1:0]                  r_idx, n_idx;
    logic [CW-1:0]                  r_pos, n_pos;
    logic [CW-1:0]                  r_nsh, n_nsh;     // pop count and shift distance
    logic [CW-1:0]                  r_count, n_count;
    sto_pkg::t_status               r_res_status, n_res_status;
    logic [TW-1:0]                  r_res_sleep, n_res_sleep;

    // Output register.
    logic                           r_ovalid, n_ovalid;
    logic [sto_pkg::HANDLE_W-1:0]   r_ohandle, n_ohandle;
    logic                           r_ofired, n_ofired;
    logic [TW-1:0]                  r_osleep, n_osleep;
    logic                           r_oempty, n_oempty;
    sto_pkg::t_status               r_ostatus, n_ostatus;
    logic                           r_olast, n_olast;

    sto_pkg::t_mem_req              mem_req;
    sto_pkg::t_entry                rdata;
    logic [TW-1:0]                  alu_a, alu_b, alu_sum;
    logic                           alu_sub;

    logic                           accept;
    logic                           slot_free;
    logic [CW-1:0]                  count_m1;
    logic [CW:0]                    src_idx;
    logic [CW-1:0]                  idx_m1;

    sto_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    sto_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_sub (alu_sub),
        .o_sum (alu_sum)
    );

    assign o_stall   = (r_state != sto_pkg::S_IDLE);
    assign accept    = i_valid && !o_stall;
    assign slot_free = !r_ovalid || !i_stall;
    assign count_m1  = r_count - CW'(1);
    assign idx_m1    = r_idx - CW'(1);
    assign src_idx   = {1'b0, r_idx} + {1'b0, r_nsh};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= sto_pkg::S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_h          <= n_h;
        r_delay      <= n_delay;
        r_now        <= n_now;
        r_t          <= n_t;
        r_idx        <= n_idx;
        r_pos        <= n_pos;
        r_nsh        <= n_nsh;
        r_res_status <= n_res_status;
        r_res_sleep  <= n_res_sleep;
        r_ohandle    <= n_ohandle;
        r_ofired     <= n_ofired;
        r_osleep     <= n_osleep;
        r_oempty     <= n_oempty;
        r_ostatus    <= n_ostatus;
        r_olast      <= n_olast;
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_h          = r_h;
        n_delay      = r_delay;
        n_now        = r_now;
        n_t          = r_t;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_nsh        = r_nsh;
        n_count      = r_count;
        n_res_status = r_res_status;
        n_res_sleep  = r_res_sleep;

        n_ovalid  = r_ovalid && i_stall;
        n_ohandle = r_ohandle;
        n_ofired  = r_ofired;
        n_osleep  = r_osleep;
        n_oempty  = r_oempty;
        n_ostatus = r_ostatus;
        n_olast   = r_olast;

        mem_req.we    = 1'b0;
        mem_req.waddr = r_idx[IW-1:0];
        mem_req.wdata = rdata;
        mem_req.raddr = r_idx[IW-1:0];

        alu_a   = r_now;
        alu_b   = rdata.due;
        alu_sub = 1'b1;

        case (r_state)
            sto_pkg::S_IDLE: begin
                if (accept) begin
                    n_mode       = sto_pkg::t_mode'(i_mode);
                    n_h          = sto_pkg::HANDLE_BITS'(i_handle);
                    n_delay      = i_delay_ms;
                    n_now        = i_now;
                    n_res_status = sto_pkg::STATUS_OK;
                    n_res_sleep  = '0;
                    n_idx        = '0;
                    n_nsh        = '0;
                    case (sto_pkg::t_mode'(i_mode))
                        sto_pkg::MODE_ADD: begin
                            if (r_count == CW'(sto_pkg::QUEUE_DEPTH)) begin
                                n_res_status = sto_pkg::STATUS_FULL;
                                n_state      = sto_pkg::S_EMIT;
                            end else begin
                                n_state = sto_pkg::S_ADD_T;
                            end
                        end
                        sto_pkg::MODE_CANCEL: begin
                            if (r_count == '0) begin
                                n_res_status = sto_pkg::STATUS_MISS;
                                n_state      = sto_pkg::S_EMIT;
                            end else begin
                                n_state = sto_pkg::S_CAN_RD;
                            end
                        end
                        sto_pkg::MODE_CHECK: begin
                            n_state = sto_pkg::S_CHK_RD;
                        end
                        sto_pkg::MODE_RESTART: begin
                            n_state = (r_count == '0) ? sto_pkg::S_EMIT : sto_pkg::S_RST_RD;
                        end
                        sto_pkg::MODE_SLEEP: begin
                            if (r_count == '0) begin
                                n_res_sleep = sto_pkg::SLEEP_INFINITE;
                                n_state     = sto_pkg::S_EMIT;
                            end else begin
                                n_state = sto_pkg::S_SLP_RD;
                            end
                        end
                        default: begin
                            n_state = sto_pkg::S_EMIT;
                        end
                    endcase
                end
            end

            // Add: compute the due time, find the first entry the new time is
            // before, open a gap by moving the tail up, then write the entry.
            sto_pkg::S_ADD_T: begin
                alu_a   = r_now;
                alu_b   = TW'(r_delay);
                alu_sub = 1'b0;
                n_t     = alu_sum;
                if (r_count == '0) begin
                    n_pos   = '0;
                    n_state = sto_pkg::S_INS;
                end else begin
                    n_state = sto_pkg::S_FIND_RD;
                end
            end
            sto_pkg::S_FIND_RD: begin
                n_state = sto_pkg::S_FIND_EV;
            end
            sto_pkg::S_FIND_EV: begin
                alu_a = r_t;
                alu_b = rdata.due;
                if (alu_sum[TW-1]) begin
                    n_pos   = r_idx;
                    n_idx   = r_count;
                    n_state = sto_pkg::S_SHUP_RD;
                end else if (r_idx == count_m1) begin
                    n_pos   = r_count;
                    n_state = sto_pkg::S_INS;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = sto_pkg::S_FIND_RD;
                end
            end
            sto_pkg::S_SHUP_RD: begin
                mem_req.raddr = idx_m1[IW-1:0];
                n_state       = sto_pkg::S_SHUP_WR;
            end
            sto_pkg::S_SHUP_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_idx[IW-1:0];
                mem_req.wdata = rdata;
                n_idx         = idx_m1;
                n_state       = (idx_m1 == r_pos) ? sto_pkg::S_INS : sto_pkg::S_SHUP_RD;
            end
            sto_pkg::S_INS: begin
                mem_req.we        = 1'b1;
                mem_req.waddr     = r_pos[IW-1:0];
                mem_req.wdata.due = r_t;
                mem_req.wdata.hdl = r_h;
                n_count           = r_count + CW'(1);
                n_state           = sto_pkg::S_EMIT;
            end

            // Cancel: search for the first matching handle, then close the gap.
            sto_pkg::S_CAN_RD: begin
                n_state = sto_pkg::S_CAN_EV;
            end
            sto_pkg::S_CAN_EV: begin
                if (rdata.hdl == r_h) begin
                    n_nsh   = CW'(1);
                    n_state = sto_pkg::S_SHDN_RD;
                end else if (r_idx == count_m1) begin
                    n_res_status = sto_pkg::STATUS_MISS;
                    n_state      = sto_pkg::S_EMIT;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = sto_pkg::S_CAN_RD;
                end
            end

            // Shift down by r_nsh places starting at r_idx, then shrink count.
            sto_pkg::S_SHDN_RD: begin
                mem_req.raddr = src_idx[IW-1:0];
                if (src_idx < {1'b0, r_count}) begin
                    n_state = sto_pkg::S_SHDN_WR;
                end else begin
                    n_count = r_count - r_nsh;
                    n_state = (r_mode == sto_pkg::MODE_CANCEL) ? sto_pkg::S_EMIT
                                                                : sto_pkg::S_IDLE;
                end
            end
            sto_pkg::S_SHDN_WR: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = r_idx[IW-1:0];
                mem_req.wdata = rdata;
                n_idx         = r_idx + CW'(1);
                n_state       = sto_pkg::S_SHDN_RD;
            end

            // Check: count the due entries at the head first, so that every
            // result word can carry the final empty flag, then pop them.
            sto_pkg::S_CHK_RD: begin
                mem_req.raddr = r_nsh[IW-1:0];
                if ((int'(r_nsh) < sto_pkg::MAX_RESULTS) && (r_nsh < r_count)) begin
                    n_state = sto_pkg::S_CHK_EV;
                end else if (r_nsh == '0) begin
                    n_state = sto_pkg::S_EMIT;
                end else begin
                    n_idx   = '0;
                    n_state = sto_pkg::S_POP_RD;
                end
            end
            sto_pkg::S_CHK_EV: begin
                alu_a = r_now;
                alu_b = rdata.due;
                if (!alu_sum[TW-1]) begin
                    n_nsh   = r_nsh + CW'(1);
                    n_state = sto_pkg::S_CHK_RD;
                end else if (r_nsh == '0) begin
                    n_state = sto_pkg::S_EMIT;
                end else begin
                    n_idx   = '0;
                    n_state = sto_pkg::S_POP_RD;
                end
            end
            sto_pkg::S_POP_RD: begin
                n_state = sto_pkg::S_POP_EV;
            end
            sto_pkg::S_POP_EV: begin
                if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_ohandle = sto_pkg::HANDLE_W'(rdata.hdl);
                    n_ofired  = 1'b1;
                    n_osleep  = '0;
                    n_oempty  = (r_count == r_nsh);
                    n_ostatus = sto_pkg::STATUS_OK;
                    n_olast   = (r_idx == r_nsh - CW'(1));
                    if (r_idx == r_nsh - CW'(1)) begin
                        n_idx   = '0;
                        n_state = sto_pkg::S_SHDN_RD;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = sto_pkg::S_POP_RD;
                    end
                end
            end

            // Restart: delta = now - head time, then add delta to every entry.
            sto_pkg::S_RST_RD: begin
                n_state = sto_pkg::S_RST_BASE;
            end
            sto_pkg::S_RST_BASE: begin
                alu_a   = r_now;
                alu_b   = rdata.due;
                n_t     = alu_sum;
                n_state = sto_pkg::S_RST_RD2;
            end
            sto_pkg::S_RST_RD2: begin
                n_state = sto_pkg::S_RST_WR;
            end
            sto_pkg::S_RST_WR: begin
                alu_a             = rdata.due;
                alu_b             = r_t;
                alu_sub           = 1'b0;
                mem_req.we        = 1'b1;
                mem_req.waddr     = r_idx[IW-1:0];
                mem_req.wdata.due = alu_sum;
                mem_req.wdata.hdl = rdata.hdl;
                if (r_idx == count_m1) begin
                    n_state = sto_pkg::S_EMIT;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = sto_pkg::S_RST_RD2;
                end
            end

            // Sleep: head time minus now, zero when the head is overdue.
            sto_pkg::S_SLP_RD: begin
                n_state = sto_pkg::S_SLP_EV;
            end
            sto_pkg::S_SLP_EV: begin
                alu_a       = rdata.due;
                alu_b       = r_now;
                n_res_sleep = alu_sum[TW-1] ? '0 : alu_sum;
                n_state     = sto_pkg::S_EMIT;
            end

            sto_pkg::S_EMIT: begin
                if (slot_free) begin
                    n_ovalid  = 1'b1;
                    n_ohandle = '0;
                    n_ofired  = 1'b0;
                    n_osleep  = r_res_sleep;
                    n_oempty  = (r_count == '0);
                    n_ostatus = r_res_status;
                    n_olast   = 1'b1;
                    n_state   = sto_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = sto_pkg::S_IDLE;
            end
        endcase
    end

    assign o_valid        = r_ovalid;
    assign o_fired_handle = r_ohandle;
    assign o_fired        = r_ofired;
    assign o_sleep_ms     = r_osleep;
    assign o_queue_empty  = r_oempty;
    assign o_status       = r_ostatus;
    assign o_last         = r_olast;

endmodule

>>> hdl/sto_alu.sv
// ----------------------------------------------------------------------------
// sto_alu - shared 32-bit adder/subtractor
// Computes a + b or a - b. The sign bit of a - b gives the wraparound
// "a is before b" compare.
// ----------------------------------------------------------------------------
module sto_alu (
    input  logic [sto_pkg::TIME_W-1:0] i_a,
    input  logic [sto_pkg::TIME_W-1:0] i_b,
    input  logic                       i_sub,
    output logic [sto_pkg::TIME_W-1:0] o_sum
);

    logic [sto_pkg::TIME_W-1:0] b_op;

    assign b_op  = i_sub ? ~i_b : i_b;
    assign o_sum = i_a + b_op + sto_pkg::TIME_W'(i_sub);

endmodule

>>> hdl/sto_ram.sv
// ----------------------------------------------------------------------------
// sto_ram - queue entry memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sto_ram (
    input  logic              i_clk,
    input  sto_pkg::t_mem_req i_req,
    output sto_pkg::t_entry   o_rdata
);

    sto_pkg::t_entry mem [sto_pkg::QUEUE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.waddr] <= i_req.wdata;
        end
        o_rdata <= mem[i_req.raddr];
    end

endmodule
